// ===== design/timing_outlier_detector_top_assert.svh =====
// Assertion macros for the timing outlier detector.
`ifndef TIMING_OUTLIER_DETECTOR_TOP_ASSERT_SVH
`define TIMING_OUTLIER_DETECTOR_TOP_ASSERT_SVH

// Same-cycle implication, reset-qualified.
`define TOD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, reset-qualified.
`define TOD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/ttod_pkg.sv =====
// Shared types and constants for the timing outlier detector.
`timescale 1ns / 1ps
`default_nettype none

package ttod_pkg;

	localparam int DUR_W       = 32;
	localparam int MIN_W       = 7;
	localparam int K_W         = 4;
	localparam int HELD_W      = 7;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 7;

	localparam logic [CFG_IDX_W-1:0] REG_MIN_SAMPLES = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_K_SIGMA     = 2'd1;

	localparam logic [MIN_W-1:0] MIN_SAMPLES_RST = 7'd10;
	localparam logic [K_W-1:0]   K_SIGMA_RST     = 4'd3;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

`default_nettype wire

// ===== design/timing_outlier_detector_top.sv =====
// Top level of the sliding-window k-sigma timing outlier detector.
//
// Usage:
//  - s_* channel: one beat per measured duration, s_tdata[31:0] = duration.
//  - cfg_* channel: register writes, always ready; index 0 = min_samples,
//    index 1 = k_sigma, others ignored. Write only while the block is idle.
//  - m_* channel: one beat per input beat. m_tuser = anomaly flag,
//    m_tdata[6:0] = samples_held, m_tdata[38:7] = window_mean, rest zero.
//  - Timing: set by the two passes over the single-port sample memory
//    (one read a cycle) and the bit-serial divider for the mean. Without
//    the test (too few samples) the second pass is skipped.
//  - s_tready is high only while idle; one beat is in work at a time, so a
//    new beat is taken only once the last one has reached the output register.
//  - Results sit in an output register, so a new beat is taken while the
//    last result waits; a finished result waits only if that register is
//    still full when the next one is done.
//  - Reset: window empty, write slot 0, min_samples 10, k_sigma 3. The
//    sample memory is not cleared; only written entries are ever read.
`timescale 1ns / 1ps
`default_nettype none
`include "timing_outlier_detector_top_assert.svh"

module timing_outlier_detector_top
	import ttod_pkg::*;
#(
	parameter int WINDOW = 64
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// slave side: [31:0] duration
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [DUR_W-1:0]      s_tdata,
	// configuration writes
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	// master side: [6:0] samples_held, [38:7] window_mean, [39] zero
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic [39:0]                m_tdata,
	// [0] anomaly
	output logic                       m_tuser
);

	localparam int ADDR_W = $clog2(WINDOW);
	localparam int CNT_W  = $clog2(WINDOW + 1);
	localparam int SUM_W  = DUR_W + CNT_W;
	localparam int SQ_W   = 2 * DUR_W + CNT_W;
	localparam int LHS_W  = 2 * DUR_W + CNT_W;
	localparam int RHS_W  = 2 * K_W + SQ_W;
	localparam int NMIN_W = (CNT_W > MIN_W) ? CNT_W : MIN_W;

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_SUM   = 4'd1;
	localparam logic [3:0] S_DIVGO = 4'd2;
	localparam logic [3:0] S_DIV   = 4'd3;
	localparam logic [3:0] S_VAR   = 4'd4;
	localparam logic [3:0] S_LAT   = 4'd5;
	localparam logic [3:0] S_DRAIN = 4'd6;
	localparam logic [3:0] S_LHS   = 4'd7;
	localparam logic [3:0] S_RHS   = 4'd8;
	localparam logic [3:0] S_CMP   = 4'd9;
	localparam logic [3:0] S_OUT   = 4'd10;

	logic [3:0]          state_q;
	logic [MIN_W-1:0]    min_q;
	logic [K_W-1:0]      k_q;
	logic [ADDR_W-1:0]   slot_q;
	logic [CNT_W-1:0]    fill_q;
	logic [CNT_W-1:0]    rd_idx_q;
	logic [DUR_W-1:0]    latest_q;
	logic [SUM_W-1:0]    sum_q;
	logic [DUR_W-1:0]    mean_q;
	logic [SQ_W-1:0]     sumsq_q;
	logic [2*DUR_W-1:0]  lat_q;
	logic [LHS_W-1:0]    lhs_q;
	logic [2*K_W-1:0]    ksq_q;
	logic [RHS_W-1:0]    rhs_q;
	logic                anom_q;

	logic                m_tvalid_q;
	logic [39:0]         m_tdata_q;
	logic                m_tuser_q;

	// sample memory
	logic [DUR_W-1:0]    mem [WINDOW];
	logic [DUR_W-1:0]    rd_data_s1;
	logic                rvalid_s1;

	// deviation / square pipeline
	logic                v_s2, tag_s2;
	logic [DUR_W-1:0]    dev_s2;
	logic                v_s3, tag_s3;
	logic [2*DUR_W-1:0]  sq_s3;

	logic                in_acc;
	logic                issue;
	logic                pass_done;
	logic                test_on;
	logic                out_free;
	logic [DUR_W-1:0]    x_in;
	logic                div_start;
	div_stat_t           div_stat;
	logic [SUM_W-1:0]    div_quot;

	assign s_tready  = state_q == S_IDLE;
	assign in_acc    = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;
	assign issue     = (state_q == S_SUM || state_q == S_VAR) && rd_idx_q != fill_q;
	assign pass_done = rd_idx_q == fill_q && !rvalid_s1;
	assign test_on   = NMIN_W'(fill_q) >= NMIN_W'(min_q);
	assign out_free  = !m_tvalid_q || m_tready;
	assign x_in      = (state_q == S_LAT) ? latest_q : rd_data_s1;
	assign div_start = state_q == S_DIVGO;

	ttod_div #(
		.DVD_W (SUM_W),
		.DVS_W (CNT_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum_q),
		.divisor  (fill_q),
		.stat     (div_stat),
		.quotient (div_quot)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q <= MIN_SAMPLES_RST;
			k_q   <= K_SIGMA_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_MIN_SAMPLES: min_q <= cfg_data[MIN_W-1:0];
				REG_K_SIGMA:     k_q   <= cfg_data[K_W-1:0];
				default: ;
			endcase
		end
	end

	// single-port sample memory, registered read
	always_ff @(posedge clk) begin
		if (in_acc)
			mem[slot_q] <= s_tdata;
		rd_data_s1 <= mem[rd_idx_q[ADDR_W-1:0]];
	end

	// sequencer and control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			slot_q     <= '0;
			fill_q     <= '0;
			rd_idx_q   <= '0;
			rvalid_s1  <= 1'b0;
			v_s2       <= 1'b0;
			v_s3       <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			rvalid_s1 <= issue;
			if (issue)
				rd_idx_q <= rd_idx_q + 1'b1;
			v_s2 <= (state_q == S_VAR && rvalid_s1) || state_q == S_LAT;
			v_s3 <= v_s2;
			// output register: load on a free slot, else clear once taken
			if (state_q == S_OUT && out_free)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;

			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						slot_q   <= (slot_q == ADDR_W'(WINDOW - 1)) ? '0 : slot_q + 1'b1;
						if (fill_q != CNT_W'(WINDOW))
							fill_q <= fill_q + 1'b1;
						rd_idx_q <= '0;
						state_q  <= S_SUM;
					end
				end
				S_SUM: begin
					if (pass_done)
						state_q <= S_DIVGO;
				end
				S_DIVGO: state_q <= S_DIV;
				S_DIV: begin
					if (div_stat.done) begin
						rd_idx_q <= '0;
						state_q  <= test_on ? S_VAR : S_OUT;
					end
				end
				S_VAR: begin
					if (pass_done)
						state_q <= S_LAT;
				end
				S_LAT: state_q <= S_DRAIN;
				S_DRAIN: begin
					if (!v_s2 && !v_s3)
						state_q <= S_LHS;
				end
				S_LHS: state_q <= S_RHS;
				S_RHS: state_q <= S_CMP;
				S_CMP: state_q <= S_OUT;
				S_OUT: begin
					if (out_free)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (in_acc) begin
			latest_q <= s_tdata;
			sum_q    <= '0;
		end
		if (state_q == S_SUM && rvalid_s1)
			sum_q <= sum_q + SUM_W'(rd_data_s1);
		if (state_q == S_DIV && div_stat.done) begin
			mean_q  <= div_quot[DUR_W-1:0];
			sumsq_q <= '0;
			anom_q  <= 1'b0;
		end

		// |x - mean|, then square; tag marks the newest sample
		dev_s2 <= (x_in >= mean_q) ? x_in - mean_q : mean_q - x_in;
		tag_s2 <= state_q == S_LAT;
		sq_s3  <= (2*DUR_W)'(dev_s2) * (2*DUR_W)'(dev_s2);
		tag_s3 <= tag_s2;
		if (v_s3 && !tag_s3)
			sumsq_q <= sumsq_q + SQ_W'(sq_s3);
		if (v_s3 && tag_s3)
			lat_q <= sq_s3;

		if (state_q == S_LHS) begin
			lhs_q <= LHS_W'(lat_q) * LHS_W'(fill_q);
			ksq_q <= (2*K_W)'(k_q) * (2*K_W)'(k_q);
		end
		if (state_q == S_RHS)
			rhs_q <= RHS_W'(ksq_q) * RHS_W'(sumsq_q);
		if (state_q == S_CMP)
			anom_q <= RHS_W'(lhs_q) > rhs_q;

		if (state_q == S_OUT && out_free) begin
			m_tdata_q <= {1'b0, mean_q, HELD_W'(fill_q)};
			m_tuser_q <= anom_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	`TOD_ASSERT_NOW(a_fill_bound, 1'b1, fill_q <= CNT_W'(WINDOW), "window fill above WINDOW")
	`TOD_ASSERT_NOW(a_mean_fits, div_stat.done, div_quot[SUM_W-1:DUR_W] == '0, "mean overflows")
	`TOD_ASSERT_NOW(a_div_owned, div_stat.busy || div_stat.done, state_q == S_DIV, "divider active outside division")
	`TOD_ASSERT_NEXT(a_out_load, state_q == S_OUT && out_free, m_tvalid_q && state_q == S_IDLE, "result not presented")

endmodule

`default_nettype wire

// ===== design/ttod_div.sv =====
// Restoring serial divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module ttod_div
	import ttod_pkg::*;
#(
	parameter int DVD_W = 39,
	parameter int DVS_W = 7
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [DVD_W-1:0] dividend,
	input  wire logic [DVS_W-1:0] divisor,
	output div_stat_t             stat,
	output logic      [DVD_W-1:0] quotient
);

	localparam int CNT_W = $clog2(DVD_W + 1);

	logic [CNT_W-1:0] cnt_q;
	logic             done_q;
	logic [DVD_W-1:0] dvd_q;   // dividend shifts out, quotient shifts in
	logic [DVS_W-1:0] dvs_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVS_W:0]   trial;
	logic             qbit;

	assign trial = {rem_q, dvd_q[DVD_W-1]};
	assign qbit  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CNT_W'(DVD_W);
			end else if (cnt_q != '0) begin
				cnt_q  <= cnt_q - 1'b1;
				done_q <= cnt_q == CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (cnt_q != '0) begin
			dvd_q <= {dvd_q[DVD_W-2:0], qbit};
			rem_q <= qbit ? DVS_W'(trial - {1'b0, dvs_q}) : trial[DVS_W-1:0];
		end
	end

	assign stat.busy = cnt_q != '0;
	assign stat.done = done_q;
	assign quotient  = dvd_q;

endmodule

`default_nettype wire

// ===== dv/timing_outlier_detector_checker.sv =====
// Watches the stream and register channels of the outlier detector, predicts and compares.
`timescale 1ns / 1ps

module timing_outlier_detector_checker
	import ttod_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	input  wire logic                  s_tready,
	input  wire logic [DUR_W-1:0]      s_tdata,
	input  wire logic                  cfg_valid,
	input  wire logic                  cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  m_tvalid,
	input  wire logic                  m_tready,
	input  wire logic [39:0]           m_tdata,
	input  wire logic                  m_tuser,
	output int                         fail_count,
	output int                         pending
);

	localparam int RING_DEPTH = 64;

	typedef struct packed {
		logic              anomaly;
		logic [HELD_W-1:0] held;
		logic [DUR_W-1:0]  mean;
	} outlier_verdict_t;

	outlier_verdict_t  expected_verdicts [$];
	logic [DUR_W-1:0]  sample_ring [RING_DEPTH];
	logic [5:0]        ring_slot;
	logic [HELD_W-1:0] held_count;
	logic [MIN_W-1:0]  min_held;
	logic [K_W-1:0]    k_thresh;
	int                results_seen;

	// one line per fault
	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("%0t ns: result %0d, %s: got 0x%0h, want 0x%0h",
			$time, results_seen, what, got, want);
		fail_count++;
	endtask

	// stores the sample, then with min_held samples runs the n*(x-mean)^2 > k^2*sum((xi-mean)^2) test
	function automatic outlier_verdict_t judge_sample(input logic [DUR_W-1:0] d);
		outlier_verdict_t v;
		logic [63:0]      total;
		logic [63:0]      mean;
		logic [63:0]      dev;
		logic [127:0]     spread_sq;
		logic [127:0]     lhs;
		logic [127:0]     rhs;
		sample_ring[ring_slot] = d;
		ring_slot = ring_slot + 1'b1;
		if (held_count < RING_DEPTH)
			held_count = held_count + 1'b1;
		total = '0;
		for (int i = 0; i < held_count; i++)
			total += sample_ring[i];
		mean = total / held_count;
		v.anomaly = 1'b0;
		if (held_count >= min_held) begin
			spread_sq = '0;
			for (int i = 0; i < held_count; i++) begin
				dev = (sample_ring[i] >= mean) ? sample_ring[i] - mean : mean - sample_ring[i];
				spread_sq += dev * dev;
			end
			dev = (d >= mean) ? d - mean : mean - d;
			lhs = dev * dev * held_count;
			rhs = spread_sq * k_thresh * k_thresh;
			v.anomaly = (lhs > rhs);
		end
		v.held = held_count;
		v.mean = mean[DUR_W-1:0];
		return v;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_verdicts.delete();
			ring_slot    = '0;
			held_count   = '0;
			min_held     = MIN_SAMPLES_RST;
			k_thresh     = K_SIGMA_RST;
			results_seen = 0;
			fail_count   = 0;
			pending      = 0;
		end else begin
			// result first: a beat taken at this edge cannot answer before it
			if (m_tvalid && m_tready) begin
				if (expected_verdicts.size() == 0) begin
					report_mismatch("result with nothing outstanding", m_tdata, '0);
				end else begin
					outlier_verdict_t want;
					want = expected_verdicts.pop_front();
					if (m_tuser !== want.anomaly)
						report_mismatch("anomaly", m_tuser, want.anomaly);
					if (m_tdata[6:0] !== want.held)
						report_mismatch("samples_held", m_tdata[6:0], want.held);
					if (m_tdata[38:7] !== want.mean)
						report_mismatch("window_mean", m_tdata[38:7], want.mean);
					if (m_tdata[39] !== 1'b0)
						report_mismatch("tdata padding", m_tdata[39], 1'b0);
				end
				results_seen++;
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_MIN_SAMPLES: min_held = cfg_data[MIN_W-1:0];
					REG_K_SIGMA:     k_thresh = cfg_data[K_W-1:0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				expected_verdicts.insert(expected_verdicts.size(), judge_sample(s_tdata));
			pending = expected_verdicts.size();
		end
	end

endmodule

// ===== dv/tb_timing_outlier_detector_top.sv =====
// Stimulus and verdict for the timing outlier detector testbench.
`timescale 1ns / 1ps

module tb_timing_outlier_detector_top;
	import ttod_pkg::*;

	// full window: two passes of 64 reads plus the serial divide, with margin
	localparam int SETTLE_CYCLES = 260;
	// receiver hold-off: long enough for the work slot and the output register to fill
	localparam int HOLD_CYCLES   = 1500;
	localparam int CHUNKS        = 6;
	localparam int CHUNK_ITEMS   = 240;
	localparam int LIMIT_CYCLES  = 2_000_000;

	// register indexes the block has no register for; writes must be dropped
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [DUR_W-1:0]      s_tdata   = '0;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	logic [39:0]           m_tdata;
	logic                  m_tuser;

	int fail_count;
	int pending;

	// idling odds in percent, set per phase by the stimulus
	int sender_idle_pct   = 23;
	int receiver_idle_pct = 47;
	// hold-off requests from the stimulus, served by the receiver process
	int hold_asked        = 0;
	int hold_served       = 0;
	int hold_left         = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	timing_outlier_detector_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	timing_outlier_detector_checker i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.fail_count (fail_count),
		.pending    (pending)
	);

	// Receiver: random back-pressure, or a long hold-off when one is asked for.
	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			m_tready <= 1'b0;
		end else if (hold_asked != hold_served) begin
			hold_served = hold_served + 1;
			hold_left   = HOLD_CYCLES - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= receiver_idle_pct);
		end
	end

	// Offer one duration beat; called and returns at a falling edge. Valid stays
	// high from beat to beat unless the sender decides to idle first.
	task automatic send_duration(input logic [DUR_W-1:0] d);
		while ($urandom_range(99) < sender_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= d;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	// One register write; valid drops for a cycle afterwards so that back to
	// back writes never raise and lower it in the same step.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	// Stop offering, let every outstanding result drain, then give the block
	// its full latency so it is idle before any register write.
	task automatic settle_block;
		s_tvalid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	initial begin
		logic [MIN_W-1:0] chunk_min [CHUNKS];
		logic [K_W-1:0]   chunk_k [CHUNKS];
		logic [DUR_W-1:0] base;
		logic [DUR_W-1:0] d;
		int               spread;
		int               pick;

		// register sets per random phase: includes min above the window and min 64
		chunk_min = '{7'd10, 7'd64, 7'd1, 7'd0, 7'd65, 7'd32};
		chunk_k   = '{4'd3, 4'd1, 4'd15, 4'd2, 4'd4, 4'd2};

		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// --- directed part ---
		// reset settings (min 10, k 3): nine flat samples below the threshold,
		// a tenth that runs the test with zero spread, then a spike and a zero
		repeat (10) send_duration(32'd100);
		send_duration(32'd1_000_000);
		send_duration(32'd0);
		settle_block();

		// zero k: any sample off the truncated mean is flagged; test from one sample
		write_reg(REG_MIN_SAMPLES, 7'd1);
		write_reg(REG_K_SIGMA, 7'd0);
		send_duration(32'hFFFF_FFFF);
		send_duration(32'h0000_0000);
		send_duration(32'h8000_0000);
		settle_block();

		// writes to spare indexes must change nothing; then zero min, widest k
		write_reg(REG_SPARE_A, 7'h7F);
		write_reg(REG_SPARE_B, 7'h00);
		write_reg(REG_MIN_SAMPLES, 7'd0);
		write_reg(REG_K_SIGMA, 7'h7F);
		send_duration(32'hFFFF_FFFF);
		send_duration(32'h0000_0000);
		settle_block();

		// min far above the window: the test never runs
		write_reg(REG_MIN_SAMPLES, 7'h7F);
		send_duration(32'hFFFF_FFFF);
		send_duration(32'h0000_0000);

		// --- random part ---
		// Mostly a tight cluster round a per-phase base so that the spread stays
		// small and the test has something to say; some spikes, some wide noise
		// and the odd rail value.
		for (int c = 0; c < CHUNKS; c++) begin
			settle_block();
			write_reg(REG_MIN_SAMPLES, chunk_min[c]);
			write_reg(REG_K_SIGMA, CFG_DATA_W'(chunk_k[c]));
			case (c / 2)
				0: begin
					sender_idle_pct   = 23;
					receiver_idle_pct = 47;
				end
				1: begin
					sender_idle_pct   = 47;
					receiver_idle_pct = 23;
				end
				default: begin
					sender_idle_pct   = 0;
					receiver_idle_pct = 0;
				end
			endcase
			// with no sender gaps the hold-off backs the block up to its input
			if (c == 4)
				hold_asked = hold_asked + 1;
			base   = ($urandom_range(3) == 0) ? DUR_W'($urandom_range(5000)) : $urandom;
			spread = $urandom_range(1, 4000);
			for (int i = 0; i < CHUNK_ITEMS; i++) begin
				pick = $urandom_range(99);
				if (pick < 70)
					d = base + DUR_W'($urandom_range(spread));
				else if (pick < 85)
					d = base + DUR_W'(spread) * DUR_W'($urandom_range(20, 2000));
				else if (pick < 95)
					d = $urandom;
				else
					d = pick[0] ? '1 : '0;
				send_duration(d);
			end
		end

		settle_block();
		if (fail_count == 0)
			$display("timing_outlier_detector_top: match");
		else
			$display("timing_outlier_detector_top: mismatch");
		$finish;
	end

	// watchdog for a hung handshake
	initial begin
		repeat (LIMIT_CYCLES) @(posedge clk);
		$display("timing_outlier_detector_top: mismatch");
		$finish;
	end

endmodule
